>>> rtl/priority_transmit_slot_queue_assert.svh
// Assertion macros for the priority transmit slot queue.
`ifndef PRIORITY_TRANSMIT_SLOT_QUEUE_ASSERT_SVH
`define PRIORITY_TRANSMIT_SLOT_QUEUE_ASSERT_SVH

// Same-cycle implication, clocked on clk, idle while rst_n is low.
`define PTSQ_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Plain invariant, built on the implication form.
`define PTSQ_ASSERT_ALWAYS(lbl, con, msg) \
  `PTSQ_ASSERT_IMP(lbl, 1'b1, con, msg)

`endif

>>> rtl/ptsq_pkg.sv
// Package: types and constants of the priority transmit slot queue.
`timescale 1ns / 1ps
`default_nettype none
package ptsq_pkg;

  localparam int SLOT_IDX_W = 6;
  localparam int SLOT_IN_W  = 8;
  localparam int HANDLE_W   = 32;
  localparam int PRIO_W     = 8;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_INSERT  = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_FREE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BAD_SLOT = 3'd3,
    ST_NULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SS_FREE     = 2'd0,
    SS_RESERVED = 2'd1,
    SS_QUEUED   = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    Q_HOLD   = 2'd0,
    Q_INSERT = 2'd1,
    Q_POP    = 2'd2
  } q_op_t;

  typedef enum logic [1:0] {
    S_HOLD    = 2'd0,
    S_RESERVE = 2'd1,
    S_QUEUE   = 2'd2,
    S_FREE    = 2'd3
  } s_op_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic                  valid;
    logic [PRIO_W-1:0]     prio;
    logic [HANDLE_W-1:0]   handle;
    logic [SLOT_IDX_W-1:0] slot;
  } q_ent_t;

  typedef struct packed {
    q_op_t  op;
    q_ent_t ent;
  } q_ctl_t;

  typedef struct packed {
    s_op_t                op;
    logic [SLOT_IN_W-1:0] target;
  } s_ctl_t;

endpackage
`default_nettype wire

>>> rtl/ptsq_in_if.sv
// Command channel interface: valid, ready and the command payload.
`timescale 1ns / 1ps
`default_nettype none
interface ptsq_in_if import ptsq_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [SLOT_IN_W-1:0] slot_in;
  logic [HANDLE_W-1:0]  data_word;
  logic [PRIO_W-1:0]    priority_req;

  modport source (output valid, cmd, slot_in, data_word, priority_req, input ready);
  modport sink   (input valid, cmd, slot_in, data_word, priority_req, output ready);
endinterface
`default_nettype wire

>>> rtl/ptsq_out_if.sv
// Result channel interface: valid, ready and the result payload.
`timescale 1ns / 1ps
`default_nettype none
interface ptsq_out_if import ptsq_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [SLOT_IDX_W-1:0] slot_out;
  logic [HANDLE_W-1:0]   data_out;

  modport source (output valid, status, slot_out, data_out, input ready);
  modport sink   (input valid, status, slot_out, data_out, output ready);
endinterface
`default_nettype wire

>>> rtl/ptsq_qcell.sv
// Queue cell: one place of the priority-sorted send queue.
`timescale 1ns / 1ps
`default_nettype none
module ptsq_qcell import ptsq_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire q_ctl_t ctl,
  input  wire q_ent_t left_ent,
  input  wire logic   left_keep,
  input  wire q_ent_t right_ent,
  output q_ent_t      ent,
  output logic        keep
);

  logic                  valid_r, valid_nxt;
  logic [PRIO_W-1:0]     prio_r, prio_nxt;
  logic [HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [SLOT_IDX_W-1:0] slot_r, slot_nxt;
  q_ent_t                ent_nxt;

  assign ent  = '{valid: valid_r, prio: prio_r, handle: handle_r, slot: slot_r};
  // A cell keeps its entry when it ranks at or above the newcomer.
  assign keep = valid_r && (prio_r >= ctl.ent.prio);

  always_comb begin
    ent_nxt = ent;
    unique case (ctl.op)
      Q_HOLD:   ent_nxt = ent;
      Q_INSERT: begin
        if (keep) begin
          ent_nxt = ent;
        end else if (left_keep) begin
          ent_nxt = ctl.ent;
        end else begin
          ent_nxt = left_ent;
        end
      end
      Q_POP:    ent_nxt = right_ent;
      default:  ent_nxt = ent;
    endcase
    valid_nxt  = ent_nxt.valid;
    prio_nxt   = ent_nxt.prio;
    handle_nxt = ent_nxt.handle;
    slot_nxt   = ent_nxt.slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r   <= prio_nxt;
    handle_r <= handle_nxt;
    slot_r   <= slot_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/ptsq_scell.sv
// Slot cell: state of one pool slot and its link in the free-slot search chain.
`timescale 1ns / 1ps
`default_nettype none
module ptsq_scell import ptsq_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire s_ctl_t ctl,
  input  wire logic   found_in,
  output logic        found_out,
  output logic        grant,
  output slot_state_t state
);

  slot_state_t state_r, state_nxt;
  logic        match;

  assign state     = state_r;
  assign match     = (ctl.target == SLOT_IN_W'(IDX));
  // Grant to the first free slot along the chain.
  assign grant     = (state_r == SS_FREE) && !found_in;
  assign found_out = found_in || (state_r == SS_FREE);

  always_comb begin
    state_nxt = state_r;
    unique case (ctl.op)
      S_HOLD:    state_nxt = state_r;
      S_RESERVE: if (grant) state_nxt = SS_RESERVED;
      S_QUEUE:   if (match) state_nxt = SS_QUEUED;
      S_FREE:    if (match) state_nxt = SS_FREE;
      default:   state_nxt = state_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_FREE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/priority_transmit_slot_queue.sv
// Top level: priority transmit slot queue over a chain of queue and slot cells.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   cmd, slot_in, data_word, priority_req
//  out_ch   out  valid/ready   status, slot_out, data_out
//
// Each command first loads the command register on transfer; the execute state
// then updates all cells at once and loads the result register.
// A new command is taken while the previous result still waits in out_ch.
// Execution stalls in place while the result register is full and not taken.
// Reset (rst_n low, synchronous) frees every slot and empties the queue.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_transmit_slot_queue_assert.svh"
module priority_transmit_slot_queue import ptsq_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ptsq_in_if.sink   in_ch,
  ptsq_out_if.source out_ch
);

  localparam int SC = SLOT_COUNT;

  // Control state
  fsm_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Command register
  cmd_t                 cmd_r, cmd_nxt;
  logic [SLOT_IN_W-1:0] slot_r, slot_nxt;
  logic [HANDLE_W-1:0]  data_r, data_nxt;
  logic [PRIO_W-1:0]    prio_r, prio_nxt;

  // Result register
  status_t               status_r, status_nxt;
  logic [SLOT_IDX_W-1:0] slot_out_r, slot_out_nxt;
  logic [HANDLE_W-1:0]   data_out_r, data_out_nxt;

  // Cell wiring
  q_ctl_t      q_ctl;
  s_ctl_t      s_ctl;
  q_ent_t      q_ent  [SC];
  logic        q_keep [SC];
  logic        found  [SC+1];
  logic        grant  [SC];
  slot_state_t sstate [SC];

  logic                  fire;
  logic                  any_free;
  logic                  slot_ok;
  logic [SLOT_IDX_W-1:0] grant_idx;

  // Queue cells: insertion shifts lower-ranked entries one place down the
  // chain, extraction shifts every entry one place towards the head.
  for (genvar i = 0; i < SC; i++) begin : g_q
    q_ent_t left_e, right_e;
    logic   left_k;
    if (i == 0) begin : g_first
      assign left_e = q_ctl.ent;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = q_ent[i-1];
      assign left_k = q_keep[i-1];
    end
    if (i == SC - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = q_ent[i+1];
    end
    ptsq_qcell u_qcell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (q_ctl),
      .left_ent  (left_e),
      .left_keep (left_k),
      .right_ent (right_e),
      .ent       (q_ent[i]),
      .keep      (q_keep[i])
    );
  end

  // Slot cells: the found flag ripples from slot 0 upwards, so the grant
  // lands on the lowest-numbered free slot.
  assign found[0] = 1'b0;
  for (genvar i = 0; i < SC; i++) begin : g_s
    ptsq_scell #(.IDX(i)) u_scell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (s_ctl),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .grant     (grant[i]),
      .state     (sstate[i])
    );
  end
  assign any_free = found[SC];

  // Encode the one-hot grant and check the named slot against the pool.
  always_comb begin
    grant_idx = '0;
    slot_ok   = 1'b0;
    for (int i = 0; i < SC; i++) begin
      if (grant[i]) grant_idx = grant_idx | SLOT_IDX_W'(i);
      if (slot_r == SLOT_IN_W'(i) && sstate[i] == SS_RESERVED) slot_ok = 1'b1;
    end
  end

  assign in_ch.ready = (state_r == FSM_IDLE);
  assign fire        = (state_r == FSM_EXEC) && (!out_valid_r || out_ch.ready);

  // Next state, cell commands and result
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    slot_nxt      = slot_r;
    data_nxt      = data_r;
    prio_nxt      = prio_r;
    status_nxt    = status_r;
    slot_out_nxt  = slot_out_r;
    data_out_nxt  = data_out_r;
    q_ctl.op      = Q_HOLD;
    q_ctl.ent     = '{valid: 1'b1, prio: prio_r, handle: data_r,
                      slot: slot_r[SLOT_IDX_W-1:0]};
    s_ctl.op      = S_HOLD;
    s_ctl.target  = slot_r;

    // Drop the result once the sink takes it.
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      FSM_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = cmd_t'(in_ch.cmd);
          slot_nxt  = in_ch.slot_in;
          data_nxt  = in_ch.data_word;
          prio_nxt  = in_ch.priority_req;
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (fire) begin
          state_nxt     = FSM_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          slot_out_nxt  = '0;
          data_out_nxt  = '0;
          unique case (cmd_r)
            CMD_RESERVE: begin
              if (!any_free) begin
                status_nxt = ST_FULL;
              end else begin
                s_ctl.op     = S_RESERVE;
                slot_out_nxt = grant_idx;
              end
            end
            CMD_INSERT: begin
              priority if (!slot_ok) begin
                status_nxt = ST_BAD_SLOT;
              end else if (data_r == '0) begin
                status_nxt = ST_NULL;
              end else begin
                s_ctl.op = S_QUEUE;
                q_ctl.op = Q_INSERT;
              end
            end
            CMD_EXTRACT: begin
              if (!q_ent[0].valid) begin
                status_nxt = ST_EMPTY;
              end else begin
                // Pop the head and free its slot.
                s_ctl.op     = S_FREE;
                s_ctl.target = SLOT_IN_W'(q_ent[0].slot);
                q_ctl.op     = Q_POP;
                data_out_nxt = q_ent[0].handle;
              end
            end
            CMD_FREE: begin
              if (!slot_ok) begin
                status_nxt = ST_BAD_SLOT;
              end else begin
                s_ctl.op = S_FREE;
              end
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    data_r     <= data_nxt;
    prio_r     <= prio_nxt;
    status_r   <= status_nxt;
    slot_out_r <= slot_out_nxt;
    data_out_r <= data_out_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.slot_out = slot_out_r;
  assign out_ch.data_out = data_out_r;

  // Checks on the cell chains
  logic [SC-1:0] qvalid_vec;
  logic [SC-1:0] queued_vec;
  logic [SC:0]   qvalid_inc;
  logic          order_ok;

  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i < SC; i++) begin
      qvalid_vec[i] = q_ent[i].valid;
      queued_vec[i] = (sstate[i] == SS_QUEUED);
    end
    for (int i = 0; i < SC - 1; i++) begin
      if (q_ent[i+1].valid && (q_ent[i].prio < q_ent[i+1].prio)) order_ok = 1'b0;
    end
  end
  assign qvalid_inc = {1'b0, qvalid_vec} + (SC+1)'(1);

  `PTSQ_ASSERT_ALWAYS(a_queued_match, $countones(queued_vec) == $countones(qvalid_vec), "queued slots and queue entries disagree")
  `PTSQ_ASSERT_ALWAYS(a_queue_packed, $onehot(qvalid_inc), "queue entries not packed at the head")
  `PTSQ_ASSERT_ALWAYS(a_queue_sorted, order_ok, "queue entries out of priority order")
  `PTSQ_ASSERT_IMP(a_err_zero, out_valid_r && status_r != ST_OK, slot_out_r == '0 && data_out_r == '0, "error result carries a slot or handle")

endmodule
`default_nettype wire
